>>> hw/rtl/kmer_presence_scan_and_query_unit_defines.svh
// Assertion macros shared by the RTL files of the k-mer presence unit.
// Simulation builds get the checks; synthesis builds get empty macros.
`ifndef KMER_PRESENCE_SCAN_AND_QUERY_UNIT_DEFINES_SVH
`define KMER_PRESENCE_SCAN_AND_QUERY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that is switched off while the active-low reset is asserted.
`define KPSQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define KPSQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KPSQ_ASSERT(name, clk, rst_n, prop, msg)
`define KPSQ_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> hw/rtl/kpsq_pkg.sv
package kpsq_pkg;

  // Fixed field widths of the item and result ports.
  localparam int unsigned CMD_W   = 1;
  localparam int unsigned BASE_W  = 3;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned LEN_W   = 4;
  // Bits that encode one nucleotide in the window and in k-mer codes.
  localparam int unsigned NUC_W   = 2;

  // Command carried by each item.
  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Control part of an item as it moves down the cell chain.
  // For a scan, lim is the run of valid bases; for a query, the start length capped at the maximum k-mer length.
  typedef struct packed {
    logic             valid;
    cmd_e             cmd;
    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] match;
  } chain_ctrl_t;

endpackage

>>> hw/rtl/kpsq_cell.sv
module kpsq_cell #(
  parameter int unsigned CELL_LEN = 1,
  parameter int unsigned KEY_W    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 clr_en_i,
  input  logic [KEY_W-1:0]     clr_addr_i,
  input  kpsq_pkg::chain_ctrl_t ctrl_i,
  input  logic [KEY_W-1:0]     key_i,
  output kpsq_pkg::chain_ctrl_t ctrl_o,
  output logic [KEY_W-1:0]     key_o
);
  import kpsq_pkg::*;

  localparam int unsigned AW    = NUC_W * CELL_LEN;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [LEN_W-1:0] MY_LEN = LEN_W'(CELL_LEN);

  // Presence bitmap for k-mers of this cell's length.
  logic bitmap_q [DEPTH];
  logic rd_q;

  chain_ctrl_t      ctrl_q;
  logic [KEY_W-1:0] key_q;

  logic [AW-1:0] addr;
  logic          set_en;

  assign addr   = key_i[AW-1:0];
  assign set_en = ctrl_i.valid && (ctrl_i.cmd == CMD_SCAN) && (MY_LEN <= ctrl_i.lim);

  // Bitmap memory: clearing pass after reset, then set bits on scans.
  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      bitmap_q[clr_addr_i[AW-1:0]] <= 1'b0;
    end else if (adv_i && set_en) begin
      bitmap_q[addr] <= 1'b1;
    end
  end

  // Registered read and the key travel with the item.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rd_q  <= bitmap_q[addr];
      key_q <= key_i;
    end
  end

  // Control stage of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // A query picks up this length when its suffix is present; longer cells come later.
  always_comb begin
    ctrl_o = ctrl_q;
    if (ctrl_q.valid && (ctrl_q.cmd == CMD_QUERY) && rd_q && (MY_LEN <= ctrl_q.lim)) begin
      ctrl_o.match = MY_LEN;
    end
  end

  assign key_o = key_q;

endmodule

>>> hw/rtl/kmer_presence_scan_and_query_unit.sv
// K-mer presence scan and query unit. Scan items shift one base into a window
// and mark every suffix of the current valid run, up to MAX_MER_LEN bases, in a
// per-length presence bitmap; query items return the longest present suffix of
// the query code no longer than its start length (0 if none), and only queries
// produce a result. After reset the unit clears all 4**MAX_MER_LEN bitmap
// addresses (65536 at the default) with in_stall_o high. After that it
// accepts one item per cycle unless the output is stalled; an item walks a
// chain of MAX_MER_LEN cells, one per k-mer length, each owning one bitmap
// memory with one registered read; query results leave through an output
// register. Items stay in order, so a query always sees all earlier scans.
module kmer_presence_scan_and_query_unit #(
  parameter int unsigned MAX_MER_LEN = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kpsq_pkg::CMD_W-1:0]   cmd_i,
  input  logic [kpsq_pkg::BASE_W-1:0]  base_code_i,
  input  logic [kpsq_pkg::CODE_W-1:0]  query_code_i,
  input  logic [kpsq_pkg::LEN_W-1:0]   start_length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kpsq_pkg::LEN_W-1:0]   match_length_o
);
  import kpsq_pkg::*;

`include "kmer_presence_scan_and_query_unit_defines.svh"

  localparam int unsigned KW = NUC_W * MAX_MER_LEN;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MER_LEN);

  logic [KW-1:0]    base_window_q, base_window_d;
  logic [LEN_W-1:0] valid_run_q, valid_run_d;
  logic             clr_busy_q;
  logic [KW-1:0]    clr_cnt_q;
  logic             out_valid_q;
  logic [LEN_W-1:0] match_q;

  logic adv;
  logic in_accept;
  logic is_scan;
  logic ambig;
  logic last_query;

  chain_ctrl_t   ctrl [MAX_MER_LEN+1];
  logic [KW-1:0] key  [MAX_MER_LEN+1];

  // The chain moves when the output register is empty or being emptied.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || !adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_scan    = (cmd_e'(cmd_i) == CMD_SCAN);
  assign ambig      = base_code_i[BASE_W-1];

  // Next window and run for a scan item.
  always_comb begin
    base_window_d = base_window_q;
    valid_run_d   = valid_run_q;
    if (ambig) begin
      valid_run_d = '0;
    end else begin
      base_window_d = KW'({base_window_q, base_code_i[NUC_W-1:0]});
      if (valid_run_q < MAX_LEN) begin
        valid_run_d = valid_run_q + 1'b1;
      end
    end
  end

  // Item entering the first cell.
  always_comb begin
    ctrl[0].valid = in_accept;
    ctrl[0].cmd   = cmd_e'(cmd_i);
    ctrl[0].match = '0;
    if (is_scan) begin
      ctrl[0].lim = valid_run_d;
      key[0]      = base_window_d;
    end else begin
      ctrl[0].lim = (start_length_i > MAX_LEN) ? MAX_LEN : start_length_i;
      key[0]      = KW'(query_code_i);
    end
  end

  // Scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_window_q <= '0;
      valid_run_q   <= '0;
    end else if (in_accept && is_scan) begin
      base_window_q <= base_window_d;
      valid_run_q   <= valid_run_d;
    end
  end

  // Clearing pass over all bitmap addresses after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // One cell per k-mer length, shortest first.
  for (genvar g = 0; g < MAX_MER_LEN; g++) begin : g_cell
    kpsq_cell #(
      .CELL_LEN(g + 1),
      .KEY_W   (KW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .clr_en_i  (clr_busy_q),
      .clr_addr_i(clr_cnt_q),
      .ctrl_i    (ctrl[g]),
      .key_i     (key[g]),
      .ctrl_o    (ctrl[g+1]),
      .key_o     (key[g+1])
    );
  end

  // A query item leaving the last cell.
  assign last_query = ctrl[MAX_MER_LEN].valid && (ctrl[MAX_MER_LEN].cmd == CMD_QUERY);

  // Output register: only queries leave a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      match_q     <= '0;
    end else if (adv) begin
      out_valid_q <= last_query;
      match_q     <= ctrl[MAX_MER_LEN].match;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_length_o = match_q;

  // Checks on the run counter, the chain result and the clearing pass.
  `KPSQ_ASSERT(a_run_bounded, clk_i, rst_ni, valid_run_q <= MAX_LEN,
               "valid run above maximum")
  `KPSQ_ASSERT(a_match_within_start, clk_i, rst_ni,
               last_query |-> (ctrl[MAX_MER_LEN].match <= ctrl[MAX_MER_LEN].lim),
               "match longer than start length")
  `KPSQ_ASSERT(a_chain_empty_in_clear, clk_i, rst_ni,
               clr_busy_q |-> (!ctrl[MAX_MER_LEN].valid && !out_valid_q),
               "item in chain during clearing pass")
  `KPSQ_ASSERT(a_clear_ends_wrapped, clk_i, rst_ni,
               $fell(clr_busy_q) |-> (clr_cnt_q == '0), "clearing pass ended early")
  `KPSQ_ASSERT(a_result_bounded, clk_i, rst_ni, out_valid_q |-> (match_q <= MAX_LEN),
               "match above maximum length")

endmodule
